@@ design/at2d_pkg.sv @@
// ----------------------------------------------------------------------------
// at2d_pkg
// Widths, rounding constants and payload types shared by the 2D affine
// transform builder.
// ----------------------------------------------------------------------------
package at2d_pkg;

	// field widths
	localparam int POS_W       = 32;
	localparam int SCALE_W     = 16;
	localparam int ANGLE_W     = 16;
	localparam int QUAD_W      = 2;
	localparam int ANGLE_OFS_W = ANGLE_W - QUAD_W;
	localparam int OUT_W       = 32;

	// quarter-wave entry, signed sine/cosine, scale product, coefficient
	localparam int SINE_W  = 15;
	localparam int TRIG_W  = SINE_W + 2;
	localparam int MUL_W   = SCALE_W + TRIG_W;
	localparam int COEF_W  = 25;
	localparam int COEF_SH = 7;

	// translation datapath
	localparam int TP_W     = POS_W + COEF_W;
	localparam int SUM_W    = TP_W + 2;
	localparam int TRANS_SH = 16;
	localparam int TX_W     = SUM_W - TRANS_SH + 1;

	// rounding offsets
	localparam logic signed [MUL_W:0]   COEF_RND  = (MUL_W + 1)'(64);
	localparam logic signed [SUM_W-1:0] TRANS_RND = SUM_W'(32768);

	// table generation constants, Q30
	localparam longint Q30_ONE     = 64'sd1 << 30;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint Q15_HALF    = 64'sd1 << 14;
	localparam longint Q15_MAX     = 64'sd32767;

	// one input item without its angle
	typedef struct packed {
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pivot_x;
		logic signed [POS_W-1:0]   pivot_y;
		logic signed [SCALE_W-1:0] scale_x;
		logic signed [SCALE_W-1:0] scale_y;
	} item_t;

	// the four linear coefficients
	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
	} coef_t;

endpackage

@@ design/affine_transform_2d_builder.sv @@
// ----------------------------------------------------------------------------
// affine_transform_2d_builder
// Builds the 2x2 matrix and translation of a 2D affine transform from
// position, pivot, scale and binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one object per transfer: position,
//   pivot, per-axis scale and a 16-bit angle (65536 is one turn). Output
//   channel out_valid/out_ready carries coef_a..coef_d and trans_x/trans_y.
//   The datapath is seven register stages: index, sine ROM read, sign fold,
//   scale multiply, pivot multiply, sum, round/saturate. A result is shown
//   from the last stage and held there until out_ready takes it.
//   Throughput is one item per cycle while out_ready is high; sine and cosine
//   come out of one quarter-wave ROM with two read ports, so both are read in
//   the same cycle. When out_ready is low the stages fill one by one and
//   in_ready drops only once every stage holds an item; nothing is dropped or
//   repeated. Reset clears every stage valid bit; the ROM is constant and
//   needs no clearing, so the block accepts items as soon as reset ends.
//   SINE_TABLE_DEPTH sets the ROM size (depth plus one entries).
// ----------------------------------------------------------------------------
module affine_transform_2d_builder #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [at2d_pkg::POS_W-1:0]   pos_x,
	input  logic signed [at2d_pkg::POS_W-1:0]   pos_y,
	input  logic signed [at2d_pkg::POS_W-1:0]   pivot_x,
	input  logic signed [at2d_pkg::POS_W-1:0]   pivot_y,
	input  logic signed [at2d_pkg::SCALE_W-1:0] scale_x,
	input  logic signed [at2d_pkg::SCALE_W-1:0] scale_y,
	input  logic        [at2d_pkg::ANGLE_W-1:0] angle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [at2d_pkg::OUT_W-1:0]   coef_a,
	output logic signed [at2d_pkg::OUT_W-1:0]   coef_b,
	output logic signed [at2d_pkg::OUT_W-1:0]   coef_c,
	output logic signed [at2d_pkg::OUT_W-1:0]   coef_d,
	output logic signed [at2d_pkg::OUT_W-1:0]   trans_x,
	output logic signed [at2d_pkg::OUT_W-1:0]   trans_y
);
	import at2d_pkg::*;

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int IPRD_W = ANGLE_OFS_W + IDX_W;

	typedef logic [SINE_W-1:0] rom_t [SINE_TABLE_DEPTH+1];

	// quarter-wave sine table, Taylor series to x^11 in Q30, rounded to Q15
	function automatic rom_t build_rom();
		rom_t   r;
		longint u;
		longint x;
		longint x2;
		longint t;
		longint s;
		longint q;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			u  = (longint'(k) * Q30_ONE) / SINE_TABLE_DEPTH;
			x  = (u * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			q  = (s + Q15_HALF) >> 15;
			r[k] = (q > Q15_MAX) ? SINE_W'(Q15_MAX) : SINE_W'(q);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Q8.8 times Q2.15, rounded half up by seven bits
	function automatic logic signed [COEF_W-1:0] scale_mul(
		input logic signed [SCALE_W-1:0] sc,
		input logic signed [TRIG_W-1:0]  tr
	);
		logic signed [MUL_W:0] p;
		p = (MUL_W + 1)'(sc) * (MUL_W + 1)'(tr) + COEF_RND;
		return p[COEF_SH+COEF_W-1:COEF_SH];
	endfunction

	// clamp to the signed output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [TX_W-1:0] v);
		priority if (&v[TX_W-1:OUT_W-1] || ~|v[TX_W-1:OUT_W-1]) begin
			return v[OUT_W-1:0];
		end else if (v[TX_W-1]) begin
			return {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// a stage loads when it is empty or its successor loads
	assign en_s7 = ~v_s7 | out_ready;
	assign en_s6 = ~v_s6 | en_s7;
	assign en_s5 = ~v_s5 | en_s6;
	assign en_s4 = ~v_s4 | en_s5;
	assign en_s3 = ~v_s3 | en_s4;
	assign en_s2 = ~v_s2 | en_s3;
	assign en_s1 = ~v_s1 | en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// stage 1: table index from the angle offset within its quadrant
	logic [IPRD_W-1:0] idx_prod;
	assign idx_prod = IPRD_W'(angle[ANGLE_OFS_W-1:0]) * IPRD_W'(SINE_TABLE_DEPTH);

	item_t             item_s1;
	logic [QUAD_W-1:0] quad_s1;
	logic [IDX_W-1:0]  k_s1;
	logic [IDX_W-1:0]  kr_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= '{pos_x: pos_x, pos_y: pos_y, pivot_x: pivot_x, pivot_y: pivot_y,
				scale_x: scale_x, scale_y: scale_y};
			quad_s1 <= angle[ANGLE_W-1:ANGLE_OFS_W];
			k_s1    <= idx_prod[IPRD_W-1:ANGLE_OFS_W];
			kr_s1   <= IDX_W'(SINE_TABLE_DEPTH) - idx_prod[IPRD_W-1:ANGLE_OFS_W];
		end
	end

	// stage 2: two ROM reads, forward and mirrored index
	item_t             item_s2;
	logic [QUAD_W-1:0] quad_s2;
	logic [SINE_W-1:0] rom_a_s2;
	logic [SINE_W-1:0] rom_b_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2  <= item_s1;
			quad_s2  <= quad_s1;
			rom_a_s2 <= SINE_ROM[k_s1];
			rom_b_s2 <= SINE_ROM[kr_s1];
		end
	end

	// stage 3: fold the quadrant into sine and cosine
	logic [SINE_W-1:0]        sin_mag, cos_mag;
	logic signed [TRIG_W-1:0] sin_pos, cos_pos;

	assign sin_mag = quad_s2[0] ? rom_b_s2 : rom_a_s2;
	assign cos_mag = quad_s2[0] ? rom_a_s2 : rom_b_s2;
	assign sin_pos = $signed({2'b00, sin_mag});
	assign cos_pos = $signed({2'b00, cos_mag});

	item_t                    item_s3;
	logic signed [TRIG_W-1:0] sin_s3;
	logic signed [TRIG_W-1:0] cos_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3 <= item_s2;
			sin_s3  <= quad_s2[1] ? -sin_pos : sin_pos;
			cos_s3  <= (quad_s2[1] ^ quad_s2[0]) ? -cos_pos : cos_pos;
		end
	end

	// stage 4: scale times sine/cosine
	item_t item_s4;
	coef_t coef_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			item_s4   <= item_s3;
			coef_s4.a <= scale_mul(item_s3.scale_x, cos_s3);
			coef_s4.b <= scale_mul(item_s3.scale_y, sin_s3);
			coef_s4.c <= -scale_mul(item_s3.scale_x, sin_s3);
			coef_s4.d <= scale_mul(item_s3.scale_y, cos_s3);
		end
	end

	// stage 5: pivot times coefficients
	item_t                  item_s5;
	coef_t                  coef_s5;
	logic signed [TP_W-1:0] p_xa_s5, p_yb_s5, p_xc_s5, p_yd_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			item_s5 <= item_s4;
			coef_s5 <= coef_s4;
			p_xa_s5 <= TP_W'(item_s4.pivot_x) * TP_W'(coef_s4.a);
			p_yb_s5 <= TP_W'(item_s4.pivot_y) * TP_W'(coef_s4.b);
			p_xc_s5 <= TP_W'(item_s4.pivot_x) * TP_W'(coef_s4.c);
			p_yd_s5 <= TP_W'(item_s4.pivot_y) * TP_W'(coef_s4.d);
		end
	end

	// stage 6: negated sum with rounding offset, Q43.16
	item_t                   item_s6;
	coef_t                   coef_s6;
	logic signed [SUM_W-1:0] sum_x_s6, sum_y_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			item_s6  <= item_s5;
			coef_s6  <= coef_s5;
			sum_x_s6 <= -SUM_W'(p_xa_s5) - SUM_W'(p_yb_s5) + TRANS_RND;
			sum_y_s6 <= -SUM_W'(p_xc_s5) - SUM_W'(p_yd_s5) + TRANS_RND;
		end
	end

	// stage 7: drop fraction, add position, saturate
	logic signed [TX_W-1:0] tx_full, ty_full;

	assign tx_full = TX_W'($signed(sum_x_s6[SUM_W-1:TRANS_SH])) + TX_W'(item_s6.pos_x);
	assign ty_full = TX_W'($signed(sum_y_s6[SUM_W-1:TRANS_SH])) + TX_W'(item_s6.pos_y);

	coef_t                   coef_s7;
	logic signed [OUT_W-1:0] tx_s7, ty_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			coef_s7 <= coef_s6;
			tx_s7   <= sat_out(tx_full);
			ty_s7   <= sat_out(ty_full);
		end
	end

	// output ports
	assign out_valid = v_s7;
	assign coef_a    = OUT_W'(coef_s7.a);
	assign coef_b    = OUT_W'(coef_s7.b);
	assign coef_c    = OUT_W'(coef_s7.c);
	assign coef_d    = OUT_W'(coef_s7.d);
	assign trans_x   = tx_s7;
	assign trans_y   = ty_s7;

endmodule
